[rtl/scgsm_pkg.sv]
package scgsm_pkg;

    // pixel window and match limits
    localparam logic [7:0] WIN_LO      = 8'd130;
    localparam logic [7:0] WIN_HI      = 8'd254;
    localparam logic [7:0] DIFF_LIMIT  = 8'd64;
    localparam int         EDGE_MARGIN = 5;
    localparam logic [9:0] DISP_MAX    = 10'd1023;

    // item kinds carried in tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_REF  = 1'b1;

    typedef struct packed {
        logic       matched;
        logic [9:0] disparity;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_srch_stat;

    function automatic logic in_window(input logic [7:0] v);
        return (v >= WIN_LO) && (v <= WIN_HI);
    endfunction

    function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

[rtl/scanline_greedy_stereo_match.sv]
// Greedy stereo matcher for one image row.
//
// Input stream (s_axis): each transfer is one pixel. tuser selects the kind:
// CMD_LOAD writes the pixel into the row store at its column (columns at or
// above MAX_WIDTH are dropped), CMD_REF presents a reference pixel. Load the
// whole second row before sending reference pixels of that row in column order.
// Output stream (m_axis): one transfer per reference pixel, none per load.
// tdata carries the disparity, tuser the matched flag.
// Configuration: i_cfg_we writes i_cfg_wdata into row_width; write it only
// while no reference pixel is in flight. Values above MAX_WIDTH act as MAX_WIDTH.
// Sequence: a load is written into the row store as it is accepted. A reference
// pixel outside the window goes straight to the done state; with a free output
// register the result then moves to the output register. Inside the window the
// search visits stored pixels in steps (issue the row-store read, check the
// returned data) until one matches or the pointer reaches the width, and then
// goes to the done state. The next transfer is taken once the search unit has
// returned to idle, which happens as the result moves to the output register.
// One item is worked on at a time; s_axis_tready is high only when idle.
// Stall: a finished result sits in the output register while the next item
// is accepted; a second result waits in the search unit until the slot frees.
// Reset: clears the search pointer, the output valid and sets row_width to 1024;
// the row store keeps whatever it held and must be reloaded.
module scanline_greedy_stereo_match #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [9:0] column, [17:10] pixel, [23:18] zero
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] disparity, [15:10] zero
    output logic        m_axis_tuser,   // [0] matched
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata
);
    import scgsm_pkg::*;

    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (PW > 11) ? PW : 11;

    logic [10:0]   r_row_width;
    logic          r_m_valid;
    t_result       r_m_res;

    logic          w_accept;
    logic          w_load_we;
    logic          w_start;
    logic          w_take;
    logic [9:0]    w_column;
    logic [7:0]    w_pixel;
    logic [WW-1:0] w_rw;
    logic [WW-1:0] w_eff;
    logic [PW-1:0] w_width;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [7:0]    w_rd_data;
    t_srch_stat    w_stat;
    t_result       w_res;

    assign w_column = s_axis_tdata[9:0];
    assign w_pixel  = s_axis_tdata[17:10];

    assign s_axis_tready = w_stat.idle;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_start       = w_accept && (s_axis_tuser == CMD_REF);
    // drop loads whose column lies outside the store
    assign w_load_we     = w_accept && (s_axis_tuser == CMD_LOAD)
                           && (32'(w_column) < 32'(MAX_WIDTH));

    // clamp the programmed width to the store depth
    assign w_rw    = WW'(r_row_width);
    assign w_eff   = (w_rw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_rw;
    assign w_width = w_eff[PW-1:0];

    // hand the result over when the output register is free or draining
    assign w_take = w_stat.done && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= 11'd1024;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_row_width <= i_cfg_wdata;
            end
            if (w_take) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (w_take) begin
            r_m_res <= w_res;
        end
    end

    scgsm_row_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (AW'(w_column)),
        .i_wdata (w_pixel),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    scgsm_search #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_column  (w_column),
        .i_pixel   (w_pixel),
        .i_width   (w_width),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .i_take    (w_take),
        .o_stat    (w_stat),
        .o_res     (w_res)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_res.disparity};
    assign m_axis_tuser  = r_m_res.matched;

    // store reads happen only during a search, never while taking input
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> !s_axis_tready)
        else $error("row store read while idle");

    // a load never starts a search
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == CMD_LOAD) |=> w_stat.idle)
        else $error("load left the search busy");

    // an unmatched result carries zero disparity
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[9:0] == '0))
        else $error("unmatched result with nonzero disparity");

    // a result handed over returns the search to idle and appears on the output
    a_take_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (w_stat.idle && m_axis_tvalid))
        else $error("result handover lost");

endmodule

[rtl/scgsm_row_store.sv]
module scgsm_row_store #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_waddr,
    input  logic [7:0]                   i_wdata,
    input  logic                         i_re,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_raddr,
    output logic [7:0]                   o_rdata
);
    logic [7:0] r_mem [MAX_WIDTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/scgsm_search.sv]
module scgsm_search #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [9:0]                     i_column,
    input  logic [7:0]                     i_pixel,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] i_width,
    output logic                           o_rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_rd_addr,
    input  logic [7:0]                     i_rd_data,
    input  logic                           i_take,
    output scgsm_pkg::t_srch_stat          o_stat,
    output scgsm_pkg::t_result             o_res
);
    import scgsm_pkg::*;

    localparam int PW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = (PW > 10) ? PW : 10;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [9:0]    r_col, n_col;
    logic [7:0]    r_pix, n_pix;
    t_result       r_res, n_res;

    logic          w_hit;
    logic          w_edge_ok;
    logic [DW-1:0] w_a, w_b, w_dist;
    logic [9:0]    w_disp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
        r_col <= n_col;
        r_pix <= n_pix;
        r_res <= n_res;
    end

    // compare the stored pixel that just came back against the reference
    always_comb begin
        w_hit     = in_window(i_rd_data) && (abs_diff8(r_pix, i_rd_data) < DIFF_LIMIT);
        w_edge_ok = ({1'b0, r_ptr} + (PW+1)'(EDGE_MARGIN)) <= {1'b0, i_width};
        w_a       = DW'(r_col);
        w_b       = DW'(r_ptr);
        w_dist    = (w_a >= w_b) ? (w_a - w_b) : (w_b - w_a);
        w_disp    = (w_dist > DW'(DISP_MAX)) ? DISP_MAX : w_dist[9:0];
    end

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_col   = r_col;
        n_pix   = r_pix;
        n_res   = r_res;
        o_rd_en = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_col = i_column;
                    n_pix = i_pixel;
                    if (i_column == '0) begin
                        n_ptr = '0;
                    end
                    if (in_window(i_pixel)) begin
                        n_state = S_ISSUE;
                    end else begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_ISSUE: begin
                if (r_ptr >= i_width) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_hit) begin
                    // leave the pointer on the match
                    n_res.matched   = w_edge_ok;
                    n_res.disparity = w_edge_ok ? w_disp : '0;
                    n_state         = S_DONE;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = S_ISSUE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    assign o_rd_addr   = r_ptr[AW-1:0];
    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scgsm_pkg::*;

    localparam int ROW_MAX      = 1024;
    localparam int ITEM_TARGET  = 1775;   // directed plus random transfers
    localparam int SETTLE_CYCLES = 8;     // lets a trailing load finish
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off

    typedef struct packed {
        logic       cmd;
        logic [9:0] column;
        logic [7:0] pixel;
    } t_pixel_item;

    // ------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // [9:0] column, [17:10] pixel, [23:18] zero
    logic        s_axis_tuser = 1'b0;  // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [9:0] disparity, [15:10] zero
    logic        m_axis_tuser;         // [0] matched
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;

    scanline_greedy_stereo_match #(
        .MAX_WIDTH(ROW_MAX)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shared state of stimulus, driver, receiver and checker
    // ------------------------------------------------------------------
    t_pixel_item pixel_q[$];      // items waiting to be offered
    t_result     disp_q[$];       // predicted disparities, oldest first
    int          items_queued = 0;
    int          err_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_asks = 0;   // bumped by the sequencer to request a hold-off
    int          hold_seen = 0;
    int          hold_left = 0;
    logic        in_xfer = 1'b0;  // input transfer happened at the last rising edge

    // Local copy of the matcher state
    logic [7:0]  row_mem [ROW_MAX];
    int          scan_ptr = 0;
    logic [10:0] row_width_q = 11'd1024;

    function automatic logic in_band(input logic [7:0] v);
        return (v >= WIN_LO) && (v <= WIN_HI);
    endfunction

    // Walk the search pointer forward over the stored row and return the
    // disparity the block should report for one reference pixel.
    function automatic t_result predict_match(input logic [9:0] col, input logic [7:0] pix);
        t_result r;
        int      best;
        int      span;
        int      w;
        int      diff;
        r    = '0;
        best = -1;
        w    = (row_width_q > ROW_MAX) ? ROW_MAX : int'(row_width_q);
        // column 0 starts a new row
        if (col == 10'd0)
            scan_ptr = 0;
        if (in_band(pix)) begin
            while (scan_ptr < w) begin
                diff = int'(pix) - int'(row_mem[scan_ptr]);
                if (diff < 0)
                    diff = -diff;
                if (in_band(row_mem[scan_ptr]) && diff < int'(DIFF_LIMIT)) begin
                    best = scan_ptr;
                    break;
                end
                scan_ptr++;
            end
            // a match too close to the right edge is rejected but keeps the pointer
            if (best >= 0 && best <= w - EDGE_MARGIN) begin
                span = int'(col) - best;
                if (span < 0)
                    span = -span;
                if (span > int'(DISP_MAX))
                    span = int'(DISP_MAX);
                r.disparity = span[9:0];
                r.matched   = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer the next pending pixel once the current one is taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_pixel_item nxt;
        if (i_rst_n && (!s_axis_tvalid || in_xfer)) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pixel_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'd0, nxt.pixel, nxt.column};
                s_axis_tuser  <= nxt.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen     <= hold_asks;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor and checker: sample at the rising edge, check results first,
    // then predict for the accepted input transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            in_xfer <= 1'b0;
        end else begin
            in_xfer <= s_axis_tvalid && s_axis_tready;
            if (i_cfg_we)
                row_width_q = i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                if (disp_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result: expected none, actual %0d matched %0b",
                             $time, m_axis_tdata[9:0], m_axis_tuser);
                end else begin
                    want = disp_q.pop_front();
                    if (m_axis_tdata[9:0] !== want.disparity) begin
                        err_count++;
                        $display("%0t: disparity mismatch: expected %0d, actual %0d",
                                 $time, want.disparity, m_axis_tdata[9:0]);
                    end
                    if (m_axis_tuser !== want.matched) begin
                        err_count++;
                        $display("%0t: matched mismatch: expected %0b, actual %0b",
                                 $time, want.matched, m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == CMD_LOAD)
                    row_mem[s_axis_tdata[9:0]] = s_axis_tdata[17:10];
                else
                    disp_q.insert(disp_q.size(),
                                  predict_match(s_axis_tdata[9:0], s_axis_tdata[17:10]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------
    task automatic push_pixel(input logic cmd, input int col, input int pix);
        t_pixel_item it;
        it.cmd    = cmd;
        it.column = col[9:0];
        it.pixel  = pix[7:0];
        pixel_q.insert(pixel_q.size(), it);
        items_queued++;
    endtask

    // mostly window values so the search finds matches, the rest anything
    function automatic int rand_pixel();
        return ($urandom_range(9) < 7) ? $urandom_range(254, 130) : $urandom_range(255, 0);
    endfunction

    // write row_width while the block is idle
    task automatic set_row_width(input int w);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w[10:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // hold until every pending pixel is taken and every result has come back
    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_axis_tvalid || disp_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int loaded_upto;   // columns 0..loaded_upto-1 hold written pixels
        int phase;
        int w;
        int nrows;
        int nref;
        int c;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed row of 12: pixels just outside and on the window edges,
        // a match past the right margin, and a tail with no match at all.
        set_row_width(12);
        push_pixel(CMD_LOAD, 0, 0);
        push_pixel(CMD_LOAD, 1, 129);
        push_pixel(CMD_LOAD, 2, 255);
        push_pixel(CMD_LOAD, 3, 130);
        push_pixel(CMD_LOAD, 4, 60);
        push_pixel(CMD_LOAD, 5, 250);
        push_pixel(CMD_LOAD, 6, 200);
        push_pixel(CMD_LOAD, 7, 100);
        push_pixel(CMD_LOAD, 8, 180);
        push_pixel(CMD_LOAD, 9, 0);
        push_pixel(CMD_LOAD, 10, 255);
        push_pixel(CMD_LOAD, 11, 140);
        loaded_upto = 12;
        push_pixel(CMD_REF, 0, 140);     // skips out-of-window entries, matches col 3
        push_pixel(CMD_REF, 1, 129);     // below the window
        push_pixel(CMD_REF, 2, 255);     // above the window
        push_pixel(CMD_REF, 3, 194);     // difference of exactly 64 is no match
        push_pixel(CMD_REF, 4, 250);     // pointer stays on its last match
        push_pixel(CMD_REF, 5, 130);     // match past the right margin, rejected
        push_pixel(CMD_REF, 6, 200);     // same rejected entry again
        push_pixel(CMD_REF, 0, 0);       // row start with an out-of-window pixel
        push_pixel(CMD_REF, 1, 254);
        push_pixel(CMD_REF, 1023, 250);  // column far beyond the width
        push_pixel(CMD_REF, 7, 131);
        push_pixel(CMD_REF, 8, 254);     // runs off the end of the row
        push_pixel(CMD_REF, 9, 200);     // pointer already at the width
        wait_drained();

        // Random rows: well-formed load-then-scan sequences with a little noise,
        // sweeping through the idle modes one phase at a time.
        phase = 0;
        while (items_queued < ITEM_TARGET) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase

            if (phase == 0 || phase == 9)
                w = ROW_MAX;
            else if (phase == 1)
                w = 5;
            else if (phase == 3)
                w = 20;
            else if ($urandom_range(7) == 0)
                w = $urandom_range(300, 41);
            else
                w = $urandom_range(40, 5);
            set_row_width(w);

            // every entry the search can reach must be written first
            if (loaded_upto < w) begin
                for (c = loaded_upto; c < w; c++)
                    push_pixel(CMD_LOAD, c, rand_pixel());
                loaded_upto = w;
            end

            // the long hold-off lets the block fill and stall its input
            if (phase == 3)
                hold_asks++;

            nrows = (w > 100) ? 1 : $urandom_range(3, 1);
            for (int row = 0; row < nrows; row++) begin
                if (w <= 100 && (row > 0 || $urandom_range(1))) begin
                    // reload the row, sometimes back to front
                    if ($urandom_range(1))
                        for (c = 0; c < w; c++)
                            push_pixel(CMD_LOAD, c, rand_pixel());
                    else
                        for (c = w - 1; c >= 0; c--)
                            push_pixel(CMD_LOAD, c, rand_pixel());
                end
                nref = (w > 64) ? 64 : w + $urandom_range(2);
                for (c = 0; c < nref; c++) begin
                    if ($urandom_range(99) < 8)
                        push_pixel(($urandom_range(1) != 0) ? CMD_REF : CMD_LOAD,
                                   $urandom_range(1023), $urandom_range(255));
                    else
                        push_pixel(CMD_REF, c, rand_pixel());
                end
            end
            wait_drained();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Run limit, far above the slowest legal run
    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
